### hdl/rank_fraction_histogram_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rank fraction histogram unit
// Shorthand for clocked checks that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RANK_FRACTION_HISTOGRAM_UNIT_MACROS_SVH
`define RANK_FRACTION_HISTOGRAM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RFH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rfh_pkg.sv
// ----------------------------------------------------------------------------
// rfh_pkg
// Shared constants of the rank fraction histogram unit.
// ----------------------------------------------------------------------------
package rfh_pkg;

  localparam int USER_W = 16;
  localparam int POS_W  = 10;
  localparam int FRAC_W = 17;

  localparam int DEF_USERS     = 65536;
  localparam int DEF_POSITIONS = 1024;

  // One in unsigned Q1.16.
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

endpackage

### hdl/rfh_ram.sv
// ----------------------------------------------------------------------------
// rfh_ram
// Simple dual-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module rfh_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 17,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/rfh_div.sv
// ----------------------------------------------------------------------------
// rfh_div
// Restoring divider producing floor(dividend * 2^16 / divisor), one bit per
// cycle. The dividend never exceeds the divisor.
// ----------------------------------------------------------------------------
module rfh_div
  import rfh_pkg::*;
#(
  parameter int CW = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CW-1:0]     dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  localparam int SW = $clog2(FRAC_W + 1);

  logic [CW:0]       rem_r, rem_nxt;
  logic [CW-1:0]     dvs_r, dvs_nxt;
  logic [FRAC_W-1:0] q_r, q_nxt;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;
  logic [CW:0]       diff;

  always_comb begin
    ge       = (rem_r >= {1'b0, dvs_r});
    diff     = ge ? (rem_r - {1'b0, dvs_r}) : rem_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, dividend};
      dvs_nxt  = divisor;
      q_nxt    = '0;
      cnt_nxt  = SW'(FRAC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so the shift fits.
      q_nxt   = {q_r[FRAC_W-2:0], ge};
      rem_nxt = {diff[CW-1:0], 1'b0};
      cnt_nxt = cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### hdl/rank_fraction_histogram_unit.sv
// ----------------------------------------------------------------------------
// rank_fraction_histogram_unit
// Percentile rank over a histogram of user positions.
// ----------------------------------------------------------------------------
// The input channel carries requests: in_tuser selects an update (0) or a
// query (1), in_tdata carries the user index and the position. An update
// records the user's new position and moves the user between histogram
// buckets; it produces no response. A query produces one response on the
// output channel: the fraction of the other known users whose position lies
// from 1 up to, but not including, the queried user's position, as unsigned
// Q1.16 truncated toward zero (65536 means 1.0).
// After reset the block runs a clearing pass over both memories, sweeping
// max(USERS, POSITIONS) addresses (65536 with the defaults); in_tready stays
// low until it ends. One request is handled at a time. An update does a
// read-modify-write of the user table and of the bucket at its new position,
// and for a user already known first of its old bucket. A query for a user at
// position p sums buckets 1 to p-1 of the histogram memory, one bucket per
// cycle, then runs the 17-step divider; the trivial answers skip both. The
// response sits in an output register, so a stalled receiver does not stop
// the next request from being taken; only a second response waits.
// ----------------------------------------------------------------------------
`include "rank_fraction_histogram_unit_macros.svh"

module rank_fraction_histogram_unit
  import rfh_pkg::*;
#(
  parameter int USERS     = DEF_USERS,
  parameter int POSITIONS = DEF_POSITIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] user_index, [25:16] position
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [16:0] rank_fraction
);

  localparam int UAW   = $clog2(USERS);
  localparam int HAW   = $clog2(POSITIONS);
  localparam int CW    = $clog2(USERS + 1);
  localparam int MAXD  = (USERS > POSITIONS) ? USERS : POSITIONS;
  localparam int CLW   = $clog2(MAXD);
  localparam int ENT_W = POS_W + 1;

  // One-hot control states.
  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOOK   = 9'b000000100,
    S_OLD_WR = 9'b000001000,
    S_NEW_RD = 9'b000010000,
    S_NEW_WR = 9'b000100000,
    S_SUM    = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_RES    = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CLW-1:0]    clr_r, clr_nxt;
  logic              cmd_r, cmd_nxt;
  logic              user_ok_r, user_ok_nxt;
  logic [UAW-1:0]    uaddr_r, uaddr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  old_r, old_nxt;     // old position on update, p on query
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     sum_r, sum_nxt;
  logic [CW-1:0]     kn_r, kn_nxt;
  logic [FRAC_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FRAC_W-1:0] out_data_r;

  logic [USER_W-1:0] in_user;
  logic [POS_W-1:0]  in_pos;
  logic              in_fire, in_user_ok, in_pos_ok;
  logic              out_ld, issue;

  logic              u_we;
  logic [UAW-1:0]    u_waddr, u_raddr;
  logic [ENT_W-1:0]  u_wdata, u_q;
  logic              h_we;
  logic [HAW-1:0]    h_waddr, h_raddr;
  logic [CW-1:0]     h_wdata, h_q;

  logic              div_start, div_done;
  logic [FRAC_W-1:0] div_quot;

  assign in_user    = in_tdata[USER_W-1:0];
  assign in_pos     = in_tdata[USER_W+POS_W-1:USER_W];
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_user_ok = (32'(in_user) < USERS);
  assign in_pos_ok  = (32'(in_pos) < POSITIONS);

  // The user table is read with the incoming index so that the entry is
  // ready when the controller reaches S_LOOK.
  assign u_raddr = UAW'(in_user);

  rfh_ram #(
    .DEPTH (USERS),
    .WIDTH (ENT_W)
  ) u_user_tab (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (u_raddr),
    .rdata (u_q)
  );

  rfh_ram #(
    .DEPTH (POSITIONS),
    .WIDTH (CW)
  ) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_q)
  );

  rfh_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (kn_r - CW'(1)),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cmd_nxt     = cmd_r;
    user_ok_nxt = user_ok_r;
    uaddr_nxt   = uaddr_r;
    pos_nxt     = pos_r;
    old_nxt     = old_r;
    idx_nxt     = idx_r;
    pend_nxt    = 1'b0;
    sum_nxt     = sum_r;
    kn_nxt      = kn_r;
    res_nxt     = res_r;
    u_we        = 1'b0;
    u_waddr     = uaddr_r;
    u_wdata     = {1'b1, pos_r};
    h_we        = 1'b0;
    h_waddr     = HAW'(pos_r);
    h_wdata     = h_q + CW'(1);
    h_raddr     = HAW'(pos_r);
    div_start   = 1'b0;
    issue       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        // Both memories are swept together; each stops at its own depth.
        u_we    = (32'(clr_r) < USERS);
        u_waddr = clr_r[UAW-1:0];
        u_wdata = '0;
        h_we    = (32'(clr_r) < POSITIONS);
        h_waddr = clr_r[HAW-1:0];
        h_wdata = '0;
        if (clr_r == CLW'(MAXD - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + CLW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_tuser;
          user_ok_nxt = in_user_ok;
          uaddr_nxt   = UAW'(in_user);
          pos_nxt     = in_pos;
          if (in_tuser == CMD_QUERY) begin
            if (kn_r == '0) begin
              res_nxt   = '0;
              state_nxt = S_RES;
            end else if (kn_r == CW'(1)) begin
              res_nxt   = FRAC_ONE;
              state_nxt = S_RES;
            end else begin
              state_nxt = S_LOOK;
            end
          end else if (in_user_ok && in_pos_ok) begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (cmd_r == CMD_UPDATE) begin
          u_we = 1'b1;
          if (u_q[POS_W]) begin
            old_nxt   = u_q[POS_W-1:0];
            h_raddr   = HAW'(u_q[POS_W-1:0]);
            state_nxt = S_OLD_WR;
          end else begin
            kn_nxt    = kn_r + CW'(1);
            state_nxt = S_NEW_WR;
          end
        end else if (!user_ok_r || !u_q[POS_W]) begin
          res_nxt   = '0;
          state_nxt = S_RES;
        end else begin
          old_nxt   = u_q[POS_W-1:0];
          idx_nxt   = POS_W'(1);
          sum_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_OLD_WR: begin
        h_we      = 1'b1;
        h_waddr   = HAW'(old_r);
        h_wdata   = h_q - CW'(1);
        state_nxt = S_NEW_RD;
      end
      S_NEW_RD: begin
        state_nxt = S_NEW_WR;
      end
      S_NEW_WR: begin
        h_we      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SUM: begin
        // Buckets 1 .. p-1 are read one per cycle; each is added once its registered read data arrives.
        h_raddr  = HAW'(idx_r);
        issue    = (idx_r < old_r);
        pend_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + POS_W'(1);
        end
        if (pend_r) begin
          sum_nxt = sum_r + h_q;
        end
        if (!issue && !pend_r) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_quot;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ld        = (state_r == S_RES) && (!out_valid_r || out_tready);
  assign out_valid_nxt = out_ld || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      kn_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      kn_r        <= kn_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    user_ok_r <= user_ok_nxt;
    uaddr_r   <= uaddr_nxt;
    pos_r     <= pos_nxt;
    old_r     <= old_nxt;
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    res_r     <= res_nxt;
    if (out_ld) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - FRAC_W){1'b0}}, out_data_r};

  // No request may be taken while the memories are being cleared.
  `RFH_ASSERT_IMP(a_no_req_in_clear, state_r == S_CLEAR, !in_tready, "request taken during clear")
  // The divider only finishes while the controller waits for it.
  `RFH_ASSERT_IMP(a_div_done_state, div_done, state_r == S_DIV, "divider done outside wait")
  // Moving a known user out of a bucket needs that bucket to be occupied.
  `RFH_ASSERT_IMP(a_old_bucket_nz, state_r == S_OLD_WR, h_q != '0, "empty bucket decremented")
  // A response never exceeds one.
  `RFH_ASSERT_IMP(a_frac_range, out_tvalid, out_data_r <= FRAC_ONE, "fraction above one")

endmodule

### dv/tb_rank_fraction_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for rank_fraction_histogram_unit
// Streams update and query requests into the unit, keeps its own copy of the
// user table and position histogram, and checks every rank fraction response
// in order against the fraction worked out from that copy.
// ----------------------------------------------------------------------------
module tb_rank_fraction_histogram_unit;
  import rfh_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_COUNT = 540;
  localparam int HOLD_EVERY   = 90;
  localparam int POOL_SIZE    = 32;
  localparam int DRAIN_CYCLES = 1100;    // longest query plus margin
  localparam int IDLE_LIMIT   = 300000;  // clearing pass and slow queries, several times

  typedef struct packed {
    logic              hold;  // wait until every response is back before sending
    logic              cmd;
    logic [USER_W-1:0] user;
    logic [POS_W-1:0]  pos;
  } request_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  request_t          pending_requests[$];
  logic [FRAC_W-1:0] awaited_fractions[$];

  // Shadow of the unit's state.
  logic [POS_W-1:0] seat_of [DEF_USERS];
  bit               seated [DEF_USERS];
  int unsigned      bucket_count [DEF_POSITIONS];
  int unsigned      seated_users = 0;

  bit in_taken    = 1'b0;
  bit out_taken   = 1'b0;
  bit send_burst  = 1'b0;
  bit recv_burst  = 1'b0;
  int send_gap    = 0;
  int recv_stall  = 0;
  int mismatches  = 0;
  int idle_cycles = 0;

  logic [USER_W-1:0] user_pool [POOL_SIZE];

  rank_fraction_histogram_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF_NS;
    clk = 1'b0;
    #CLK_HALF_NS;
  end

  // Moves a user to a new position, taking it out of its old bucket if it had one.
  task automatic seat_user(logic [USER_W-1:0] user, logic [POS_W-1:0] pos);
    if (seated[user]) begin
      bucket_count[seat_of[user]]--;
    end else begin
      seated[user] = 1'b1;
      seated_users++;
    end
    seat_of[user] = pos;
    bucket_count[pos]++;
  endtask

  // Fraction of the other known users sitting at positions 1 .. p-1.
  function automatic logic [FRAC_W-1:0] rank_fraction_of(logic [USER_W-1:0] user);
    longint unsigned behind;
    longint unsigned frac;
    int k;
    behind = 0;
    if (seated_users == 0) return '0;
    if (seated_users == 1) return FRAC_ONE;
    if (!seated[user]) return '0;
    for (k = 1; k < seat_of[user]; k++) behind += bucket_count[k];
    frac = (behind << 16) / (seated_users - 1);
    return frac[FRAC_W-1:0];
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic report_mismatch(string what, logic [FRAC_W-1:0] got,
                                 logic [FRAC_W-1:0] want);
    $display("mismatch at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_request(logic hold, logic cmd, logic [USER_W-1:0] user,
                               logic [POS_W-1:0] pos);
    request_t req;
    req.hold = hold;
    req.cmd  = cmd;
    req.user = user;
    req.pos  = pos;
    pending_requests.push_back(req);
  endtask

  // Monitor: handshakes are sampled at the rising edge. The response is checked
  // before a query taken at the same edge is added, since it cannot belong to it.
  always @(posedge clk) begin
    logic [FRAC_W-1:0] want;
    in_taken  = rst_n && in_tvalid && in_tready;
    out_taken = rst_n && out_tvalid && out_tready;
    if (out_taken) begin
      if (awaited_fractions.size() == 0) begin
        report_mismatch("response with no query outstanding", out_tdata[FRAC_W-1:0], '0);
      end else begin
        want = awaited_fractions.pop_front();
        if (out_tdata[FRAC_W-1:0] !== want)
          report_mismatch("rank_fraction", out_tdata[FRAC_W-1:0], want);
      end
    end
    if (in_taken) begin
      if (in_tuser == CMD_QUERY)
        awaited_fractions.push_back(rank_fraction_of(in_tdata[USER_W-1:0]));
      else
        seat_user(in_tdata[USER_W-1:0], in_tdata[USER_W+POS_W-1:USER_W]);
    end
  end

  // Request driver: one valid assignment per falling edge.
  always @(negedge clk) begin
    logic     valid_next;
    request_t req;
    valid_next = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && in_taken) begin
        valid_next = 1'b0;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_gap = draw_wait(send_burst);
      end
      if (!valid_next && pending_requests.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!(pending_requests[0].hold && awaited_fractions.size() > 0)) begin
          req = pending_requests.pop_front();
          in_tdata   <= {{(32 - USER_W - POS_W){1'b0}}, req.pos, req.user};
          in_tuser   <= req.cmd;
          valid_next = 1'b1;
        end
      end
    end
    in_tvalid <= valid_next;
  end

  // Response side: after each response, hold ready low for a drawn number of
  // cycles in which a response is waiting.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_stall = draw_wait(recv_burst);
      end
      if (recv_stall > 0) begin
        out_tready <= 1'b0;
        if (out_tvalid) recv_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int               n;
    int               pick;
    logic             cmd;
    logic [USER_W-1:0] user;
    logic [POS_W-1:0]  pos;

    // Directed part: empty table, a single known user, unknown users, the
    // position extremes, a repeated position and moves between buckets.
    queue_request(1'b0, CMD_QUERY,  16'h0000, 10'd0);    // nobody known
    queue_request(1'b0, CMD_UPDATE, 16'h1234, 10'd5);
    queue_request(1'b0, CMD_QUERY,  16'h1234, 10'd0);    // sole user
    queue_request(1'b0, CMD_QUERY,  16'hFFFF, 10'd0);    // sole user known, asker unknown
    queue_request(1'b1, CMD_UPDATE, 16'h0000, 10'd0);    // waits for the query before it
    queue_request(1'b0, CMD_QUERY,  16'hFFFF, 10'd1023); // unknown user
    queue_request(1'b0, CMD_QUERY,  16'h0000, 10'd0);    // at position zero
    queue_request(1'b0, CMD_UPDATE, 16'hFFFF, 10'd1023);
    queue_request(1'b0, CMD_UPDATE, 16'h5555, 10'd1);
    queue_request(1'b0, CMD_UPDATE, 16'hAAAA, 10'd2);
    queue_request(1'b0, CMD_QUERY,  16'hFFFF, 10'd0);    // all but the user at position zero behind
    queue_request(1'b0, CMD_QUERY,  16'h5555, 10'd0);    // at position one
    queue_request(1'b0, CMD_QUERY,  16'hAAAA, 10'd0);
    queue_request(1'b0, CMD_UPDATE, 16'hAAAA, 10'd2);    // same position again
    queue_request(1'b0, CMD_QUERY,  16'hAAAA, 10'h2AA);
    queue_request(1'b0, CMD_UPDATE, 16'h1234, 10'd1023);
    queue_request(1'b0, CMD_QUERY,  16'h1234, 10'd0);
    queue_request(1'b0, CMD_UPDATE, 16'hFFFF, 10'd0);    // back down to zero
    queue_request(1'b0, CMD_QUERY,  16'h1234, 10'h155);
    queue_request(1'b0, CMD_QUERY,  16'h5555, 10'd1023);
    queue_request(1'b0, CMD_UPDATE, 16'h5555, 10'd1022);
    queue_request(1'b0, CMD_QUERY,  16'h5555, 10'd0);

    // Random part: most requests touch a small pool of users so that queries
    // mostly hit known users, and most positions are low to keep queries short.
    for (n = 0; n < POOL_SIZE - 2; n++) user_pool[n] = USER_W'($urandom_range(0, 65535));
    user_pool[POOL_SIZE-2] = 16'h0000;
    user_pool[POOL_SIZE-1] = 16'hFFFF;
    for (n = 0; n < RANDOM_COUNT; n++) begin
      cmd  = ($urandom_range(0, 99) < 55) ? CMD_UPDATE : CMD_QUERY;
      user = ($urandom_range(0, 9) == 0) ? USER_W'($urandom_range(0, 65535))
                                         : user_pool[$urandom_range(0, POOL_SIZE-1)];
      pick = $urandom_range(0, 99);
      if (cmd == CMD_QUERY)
        pos = POS_W'($urandom_range(0, 1023));
      else if (pick < 80)
        pos = POS_W'($urandom_range(0, 40));
      else if (pick < 92)
        pos = POS_W'($urandom_range(0, 1023));
      else begin
        case ($urandom_range(0, 3))
          0:       pos = 10'd0;
          1:       pos = 10'd1;
          2:       pos = 10'd1022;
          default: pos = 10'd1023;
        endcase
      end
      queue_request(n % HOLD_EVERY == 0, cmd, user, pos);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() > 0 || in_tvalid) @(posedge clk);
    while (awaited_fractions.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/rfh_pkg.sv
hdl/rfh_ram.sv
hdl/rfh_div.sv
hdl/rank_fraction_histogram_unit.sv
dv/tb_rank_fraction_histogram_unit.sv
